// File: rtl/sstd_pkg.sv
// Package for the serial-set time-of-day clock.
// Holds the sequencer state type, character codes, time limits and the
// classification result of the digit unit. Depends on nothing.
`timescale 1ns / 1ps

package sstd_pkg;

   localparam int CHAR_W = 8;
   localparam int TIME_W = 7;

   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_S     = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   localparam logic [TIME_W-1:0] HOUR_RESET    = 7'd12;
   localparam logic [TIME_W-1:0] SEC_PER_MIN   = 7'd60;
   localparam logic [TIME_W-1:0] MIN_PER_HOUR  = 7'd60;
   localparam logic [TIME_W-1:0] HOURS_PER_DAY = 7'd24;
   localparam logic [TIME_W-1:0] VALUE_MAX     = 7'd99;

   localparam int POS_HOURS   = 2;
   localparam int POS_MINUTES = 5;
   localparam int POS_SECONDS = 8;
   localparam int POS_CMD     = 1;

   typedef enum logic [1:0] {
      FIELD_HOURS,
      FIELD_MINUTES,
      FIELD_SECONDS
   } sstd_field_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_SKIP_RD,
      ST_SKIP_EV,
      ST_DIGIT_RD,
      ST_DIGIT_EV,
      ST_EMIT
   } sstd_state_type;

   typedef struct packed {
      logic              is_space;
      logic              is_minus;
      logic              is_plus;
      logic              is_digit;
      logic              is_nul;
      logic [TIME_W-1:0] next_value;
   } sstd_alu_type;

endpackage

// File: rtl/sstd_req_if.sv
// Request channel interface: valid/ready handshake carrying one beat of
// action and received byte. Depends on sstd_pkg.
`timescale 1ns / 1ps

interface sstd_req_if;
   import sstd_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [CHAR_W-1:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// File: rtl/sstd_rsp_if.sv
// Response channel interface: valid/ready handshake carrying one beat of
// the current time and its cause. Depends on sstd_pkg.
`timescale 1ns / 1ps

interface sstd_rsp_if;
   import sstd_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] hours;
   logic [TIME_W-1:0] minutes;
   logic [TIME_W-1:0] seconds;
   logic              cause;

   modport source (output valid, output hours, output minutes, output seconds,
                   output cause, input ready);
   modport sink   (input valid, input hours, input minutes, input seconds,
                   input cause, output ready);
endinterface

// File: rtl/sstd_line_ram.sv
// Line buffer memory: one write port and one registered read port.
// Depends on sstd_pkg for the character width.
`timescale 1ns / 1ps

module sstd_line_ram #(
   parameter int DEPTH = 30,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [sstd_pkg::CHAR_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [sstd_pkg::CHAR_W-1:0] rd_data
);
   import sstd_pkg::*;

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sstd_digit_alu.sv
// Shared character unit: classifies one line character and forms the next
// saturated decimal accumulator value. Depends on sstd_pkg.
`timescale 1ns / 1ps

module sstd_digit_alu (
   input  logic [sstd_pkg::CHAR_W-1:0] char_in,
   input  logic [sstd_pkg::TIME_W-1:0] acc_in,
   output sstd_pkg::sstd_alu_type      result
);
   import sstd_pkg::*;

   localparam int SUM_W = TIME_W + 3;

   logic [SUM_W-1:0] acc_wide;
   logic [SUM_W-1:0] sum;

   always_comb begin
      acc_wide = {3'b000, acc_in};
      // acc * 10 as (acc << 3) + (acc << 1), plus the digit.
      sum = (acc_wide << 3) + (acc_wide << 1) + {{(SUM_W-4){1'b0}}, char_in[3:0]};

      result.is_space = (char_in == CHAR_SPACE) ||
                        ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
      result.is_minus = (char_in == CHAR_MINUS);
      result.is_plus  = (char_in == CHAR_PLUS);
      result.is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
      result.is_nul   = (char_in == CHAR_NUL);
      result.next_value = (sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX : sum[TIME_W-1:0];
   end

endmodule

// File: rtl/serial_set_time_of_day_clock.sv
// Serial-set time-of-day clock. Requests are taken only while idle. A stored
// byte is written there; a tick updates the time and moves to the emit state,
// which waits for the output register to be free, loads the reading and returns
// to idle. A line end scans positions 0..8 to check the S: prefix and the line
// length, then parses each field by reading and evaluating one character at a
// time. Synchronous reset: 12:00:00, empty line; the line store is not cleared.
`timescale 1ns / 1ps

module serial_set_time_of_day_clock #(
   parameter int LINE_CAPACITY = 30
) (
   input  logic       clock,
   input  logic       reset,
   sstd_req_if.sink   req_chan,
   sstd_rsp_if.source rsp_chan
);
   import sstd_pkg::*;

   localparam int AW    = $clog2(LINE_CAPACITY);
   localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

   sstd_state_type    state_ff, state_in;
   sstd_field_type    field_ff, field_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [TIME_W-1:0] acc_ff, acc_in;
   logic              neg_ff, neg_in;
   logic              set_ok_ff, set_ok_in;
   logic              long_ok_ff, long_ok_in;
   logic              cause_ff, cause_in;
   logic              in_range_ff;
   logic [TIME_W-1:0] hour_ff, hour_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic [TIME_W-1:0] sec_ff, sec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_hours_ff, rsp_minutes_ff, rsp_seconds_ff;
   logic              rsp_cause_ff;
   logic              rsp_load;

   logic              wr_en;
   logic [CHAR_W-1:0] ram_data;
   logic [CHAR_W-1:0] cur_char;
   logic [TIME_W-1:0] field_value;
   logic [TIME_W-1:0] sec_inc, min_inc, hour_inc;
   sstd_alu_type      alu;

   sstd_line_ram #(.DEPTH(LINE_CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (req_chan.rx_byte),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (ram_data)
   );

   // Positions at or past the line end read as a zero byte.
   assign cur_char = in_range_ff ? ram_data : CHAR_NUL;

   sstd_digit_alu u_alu (
      .char_in (cur_char),
      .acc_in  (acc_ff),
      .result  (alu)
   );

   assign field_value = neg_ff ? '0 : acc_ff;
   assign sec_inc  = sec_ff + 7'd1;
   assign min_inc  = min_ff + 7'd1;
   assign hour_inc = hour_ff + 7'd1;

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      field_in   = field_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      set_ok_in  = set_ok_ff;
      long_ok_in = long_ok_ff;
      cause_in   = cause_ff;
      hour_in    = hour_ff;
      min_in     = min_ff;
      sec_in     = sec_ff;
      wr_en      = 1'b0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.action) begin
                  sec_in   = sec_inc;
                  cause_in = 1'b0;
                  if (sec_inc >= SEC_PER_MIN) begin
                     sec_in = '0;
                     min_in = min_inc;
                     if (min_inc >= MIN_PER_HOUR) begin
                        min_in  = '0;
                        hour_in = (hour_inc >= HOURS_PER_DAY) ? '0 : hour_inc;
                     end
                  end
                  state_in = ST_EMIT;
               end else if ((req_chan.rx_byte == CHAR_LF) ||
                            (req_chan.rx_byte == CHAR_CR)) begin
                  pos_in     = '0;
                  set_ok_in  = 1'b1;
                  long_ok_in = 1'b1;
                  state_in   = ST_SCAN_RD;
               end else if (len_ff < LEN_W'(LINE_CAPACITY)) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + 1'b1;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            if (pos_ff == '0) begin
               set_ok_in = set_ok_ff && (cur_char == CHAR_S);
            end else if (pos_ff == LEN_W'(POS_CMD)) begin
               set_ok_in = set_ok_ff && (cur_char == CHAR_COLON);
            end
            long_ok_in = long_ok_ff && !alu.is_nul;
            if (pos_ff == LEN_W'(POS_SECONDS)) begin
               if (set_ok_ff) begin
                  pos_in   = LEN_W'(POS_HOURS);
                  field_in = FIELD_HOURS;
                  acc_in   = '0;
                  neg_in   = 1'b0;
                  state_in = ST_SKIP_RD;
               end else begin
                  len_in   = '0;
                  state_in = ST_IDLE;
               end
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SKIP_RD: begin
            state_in = ST_SKIP_EV;
         end
         ST_SKIP_EV: begin
            state_in = ST_DIGIT_RD;
            if (alu.is_space) begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_SKIP_RD;
            end else if (alu.is_minus) begin
               neg_in = 1'b1;
               pos_in = pos_ff + 1'b1;
            end else if (alu.is_plus) begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_DIGIT_RD: begin
            state_in = ST_DIGIT_EV;
         end
         ST_DIGIT_EV: begin
            if (alu.is_digit) begin
               acc_in   = alu.next_value;
               pos_in   = pos_ff + 1'b1;
               state_in = ST_DIGIT_RD;
            end else begin
               acc_in   = '0;
               neg_in   = 1'b0;
               state_in = ST_SKIP_RD;
               case (field_ff)
                  FIELD_HOURS: begin
                     hour_in  = field_value;
                     field_in = FIELD_MINUTES;
                     pos_in   = LEN_W'(POS_MINUTES);
                  end
                  FIELD_MINUTES: begin
                     min_in = field_value;
                     if (long_ok_ff) begin
                        field_in = FIELD_SECONDS;
                        pos_in   = LEN_W'(POS_SECONDS);
                     end else begin
                        sec_in   = '0;
                        len_in   = '0;
                        cause_in = 1'b1;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     sec_in   = field_value;
                     len_in   = '0;
                     cause_in = 1'b1;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // Wait for the output register to be free before loading it.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         field_ff     <= FIELD_HOURS;
         len_ff       <= '0;
         pos_ff       <= '0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         set_ok_ff    <= 1'b0;
         long_ok_ff   <= 1'b0;
         cause_ff     <= 1'b0;
         in_range_ff  <= 1'b0;
         hour_ff      <= HOUR_RESET;
         min_ff       <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         field_ff     <= field_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         set_ok_ff    <= set_ok_in;
         long_ok_ff   <= long_ok_in;
         cause_ff     <= cause_in;
         in_range_ff  <= (pos_ff < len_ff);
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hours_ff   <= hour_ff;
         rsp_minutes_ff <= min_ff;
         rsp_seconds_ff <= sec_ff;
         rsp_cause_ff   <= cause_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.hours   = rsp_hours_ff;
   assign rsp_chan.minutes = rsp_minutes_ff;
   assign rsp_chan.seconds = rsp_seconds_ff;
   assign rsp_chan.cause   = rsp_cause_ff;

endmodule

// File: test/serial_set_time_of_day_clock_tb.sv
// Self-checking testbench for the serial-set time-of-day clock: directed rows,
// then random set lines, noise and ticks under several idle and stall phases.
// Depends on sstd_pkg and the sstd_req_if and sstd_rsp_if interfaces.
`timescale 1ns / 1ps

module serial_set_time_of_day_clock_tb;
   import sstd_pkg::*;

   localparam int LINE_CAP      = 30;
   localparam int ITEM_TARGET   = 1200;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int REPORT_MAX    = 10;

   localparam logic ACT_BYTE   = 1'b0;
   localparam logic ACT_TICK   = 1'b1;
   localparam logic CAUSE_TICK = 1'b0;
   localparam logic CAUSE_SET  = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] hours;
      logic [TIME_W-1:0] minutes;
      logic [TIME_W-1:0] seconds;
      logic              cause;
   } clock_reading_type;

   typedef struct packed {
      logic              act;
      logic [CHAR_W-1:0] char_code;
      logic              typed;
      clock_reading_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   sstd_req_if req_chan ();
   sstd_rsp_if rsp_chan ();

   serial_set_time_of_day_clock #(
      .LINE_CAPACITY(LINE_CAP)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the clock and the line being received.
   logic [CHAR_W-1:0] shadow_line [LINE_CAP];
   int                shadow_len;
   logic [TIME_W-1:0] shadow_hours;
   logic [TIME_W-1:0] shadow_minutes;
   logic [TIME_W-1:0] shadow_seconds;

   clock_reading_type pending_times [$];
   int                fail_count;
   int                items_done;
   int                req_idle_pct;
   int                rsp_stall_pct;
   int                cycle_count;

   stim_row_type directed_rows [23];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [CHAR_W-1:0] line_char(input int pos);
      if (pos < shadow_len && pos < LINE_CAP) begin
         return shadow_line[pos];
      end
      return CHAR_NUL;
   endfunction

   // Decimal field in the style of atoi, saturating at the largest value.
   function automatic logic [TIME_W-1:0] parse_time_field(input int start);
      int                p;
      int                value;
      logic [CHAR_W-1:0] c;
      bit                negative;
      p        = start;
      value    = 0;
      negative = 1'b0;
      while (p <= LINE_CAP) begin
         c = line_char(p);
         if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            p++;
         end else begin
            break;
         end
      end
      c = line_char(p);
      if (c == CHAR_MINUS) begin
         negative = 1'b1;
         p++;
      end else if (c == CHAR_PLUS) begin
         p++;
      end
      while (p <= LINE_CAP) begin
         c = line_char(p);
         if (c < CHAR_ZERO || c > CHAR_NINE) begin
            break;
         end
         value = value * 10 + int'(c - CHAR_ZERO);
         if (value > int'(VALUE_MAX)) begin
            value = int'(VALUE_MAX);
         end
         p++;
      end
      return negative ? '0 : TIME_W'(value);
   endfunction

   // Applies one accepted beat to the shadow clock; true when it gives a result.
   function automatic bit shadow_clock_step(input logic act, input logic [CHAR_W-1:0] ch,
                                            output clock_reading_type reading);
      bit is_set;
      bit long_line;
      reading = '0;
      if (act == ACT_TICK) begin
         shadow_seconds++;
         if (shadow_seconds >= SEC_PER_MIN) begin
            shadow_seconds = '0;
            shadow_minutes++;
            if (shadow_minutes >= MIN_PER_HOUR) begin
               shadow_minutes = '0;
               shadow_hours++;
               if (shadow_hours >= HOURS_PER_DAY) begin
                  shadow_hours = '0;
               end
            end
         end
         reading = '{shadow_hours, shadow_minutes, shadow_seconds, CAUSE_TICK};
         return 1'b1;
      end
      if (ch != CHAR_LF && ch != CHAR_CR) begin
         if (shadow_len < LINE_CAP) begin
            shadow_line[shadow_len] = ch;
            shadow_len++;
         end
         return 1'b0;
      end
      is_set = (line_char(0) == CHAR_S && line_char(POS_CMD) == CHAR_COLON);
      if (is_set) begin
         long_line = 1'b1;
         for (int p = 0; p <= POS_SECONDS; p++) begin
            if (line_char(p) == CHAR_NUL) begin
               long_line = 1'b0;
            end
         end
         shadow_hours   = parse_time_field(POS_HOURS);
         shadow_minutes = parse_time_field(POS_MINUTES);
         shadow_seconds = long_line ? parse_time_field(POS_SECONDS) : '0;
         reading = '{shadow_hours, shadow_minutes, shadow_seconds, CAUSE_SET};
      end
      shadow_len = 0;
      return is_set;
   endfunction

   function automatic logic [CHAR_W-1:0] random_text_byte();
      logic [CHAR_W-1:0] b;
      b = CHAR_W'($urandom_range(0, 255));
      while (b == CHAR_LF || b == CHAR_CR) begin
         b = CHAR_W'($urandom_range(0, 255));
      end
      return b;
   endfunction

   // Digits most often, with whitespace, signs, colons and the odd zero byte.
   function automatic logic [CHAR_W-1:0] random_field_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
      end else if (r < 52) begin
         return CHAR_SPACE;
      end else if (r < 56) begin
         // Tab, vertical tab or form feed.
         return ($urandom_range(0, 2) == 0) ? CHAR_TAB :
                CHAR_CR - CHAR_W'($urandom_range(1, 2));
      end else if (r < 61) begin
         return CHAR_PLUS;
      end else if (r < 66) begin
         return CHAR_MINUS;
      end else if (r < 76) begin
         return CHAR_COLON;
      end else if (r < 78) begin
         return CHAR_NUL;
      end
      return random_text_byte();
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("%s", msg);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic act, input logic [CHAR_W-1:0] ch, input logic typed,
                            input clock_reading_type typed_reading);
      clock_reading_type predicted;
      bit                dropped;
      while (req_idle_pct != 0 && $urandom_range(1, 100) <= req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.action  <= act;
      req_chan.rx_byte <= ch;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      dropped = (act == ACT_BYTE && ch != CHAR_LF && ch != CHAR_CR && shadow_len >= LINE_CAP);
      if (shadow_clock_step(act, ch, predicted)) begin
         pending_times.push_back(typed ? typed_reading : predicted);
      end
      if (!dropped) begin
         items_done++;
      end
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_beat(ACT_TICK, CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // Holds the sender off until every outstanding reading has arrived.
   task automatic drain_readings();
      req_chan.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_times.size() != 0);
   endtask

   task automatic send_random_line();
      logic [CHAR_W-1:0] line_bytes [$];
      int                kind;
      int                len;
      int                v;
      int                burst;
      kind  = $urandom_range(0, 99);
      burst = 0;
      if (kind < 60) begin
         // Set line with random field contents; a few have a broken prefix.
         v = $urandom_range(0, 99);
         len = (v < 70) ? $urandom_range(2, 12) :
               (v < 90) ? $urandom_range(13, LINE_CAP) :
               $urandom_range(LINE_CAP + 1, LINE_CAP + 6);
         line_bytes.push_back(CHAR_S);
         line_bytes.push_back(CHAR_COLON);
         for (int i = 2; i < len; i++) begin
            line_bytes.push_back(random_field_byte());
         end
         if ($urandom_range(0, 9) == 0) begin
            line_bytes[$urandom_range(0, 1)] = random_text_byte();
         end
      end else if (kind < 75) begin
         // Well-formed time, often near a carry, followed by a burst of ticks.
         for (int f = 0; f < 3; f++) begin
            if (f == 0) begin
               line_bytes.push_back(CHAR_S);
               v = ($urandom_range(0, 1) == 0) ? 23 : $urandom_range(0, 99);
            end else if (f == 1) begin
               v = ($urandom_range(0, 1) == 0) ? 59 : $urandom_range(0, 99);
            end else begin
               v = ($urandom_range(0, 1) == 0) ? $urandom_range(55, 59) : $urandom_range(0, 99);
            end
            line_bytes.push_back(CHAR_COLON);
            line_bytes.push_back(CHAR_ZERO + CHAR_W'(v / 10));
            line_bytes.push_back(CHAR_ZERO + CHAR_W'(v % 10));
         end
         burst = $urandom_range(1, 8);
      end else begin
         len = $urandom_range(0, LINE_CAP + 4);
         for (int i = 0; i < len; i++) begin
            line_bytes.push_back(random_text_byte());
         end
      end
      foreach (line_bytes[i]) begin
         if ($urandom_range(0, 9) == 0) begin
            send_tick();
         end
         send_beat(ACT_BYTE, line_bytes[i], 1'b0, '0);
      end
      send_beat(ACT_BYTE, ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF, 1'b0, '0);
      repeat (burst) begin
         send_tick();
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= (rsp_stall_pct == 0 || $urandom_range(1, 100) > rsp_stall_pct);
   end

   always @(posedge clock) begin : check_readings
      clock_reading_type got;
      clock_reading_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.hours, rsp_chan.minutes, rsp_chan.seconds, rsp_chan.cause};
         if (pending_times.size() == 0) begin
            note_failure($sformatf("unexpected reading %0d:%0d:%0d cause %0d",
                                   got.hours, got.minutes, got.seconds, got.cause));
         end else begin
            want = pending_times.pop_front();
            if (got.hours !== want.hours || got.minutes !== want.minutes ||
                got.seconds !== want.seconds || got.cause !== want.cause) begin
               note_failure($sformatf({"reading mismatch: expected %0d:%0d:%0d cause %0d,",
                                       " got %0d:%0d:%0d cause %0d"},
                                      want.hours, want.minutes, want.seconds, want.cause,
                                      got.hours, got.minutes, got.seconds, got.cause));
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL serial_set_time_of_day_clock");
      $finish;
   end

   initial begin : stimulus
      directed_rows = '{
         '{ACT_TICK, CHAR_NUL,   1'b1, '{7'd12, 7'd0, 7'd1, CAUSE_TICK}},
         '{ACT_BYTE, CHAR_S,     1'b0, '0},
         '{ACT_BYTE, CHAR_COLON, 1'b0, '0},
         '{ACT_BYTE, CHAR_NINE,  1'b0, '0},
         '{ACT_BYTE, CHAR_NINE,  1'b0, '0},
         '{ACT_BYTE, CHAR_COLON, 1'b0, '0},
         '{ACT_BYTE, CHAR_NINE,  1'b0, '0},
         '{ACT_BYTE, CHAR_NINE,  1'b0, '0},
         '{ACT_BYTE, CHAR_COLON, 1'b0, '0},
         '{ACT_BYTE, CHAR_NINE,  1'b0, '0},
         '{ACT_BYTE, CHAR_NINE,  1'b0, '0},
         '{ACT_BYTE, CHAR_CR,    1'b1, '{7'd99, 7'd99, 7'd99, CAUSE_SET}},
         // Out-of-range values all carry to zero on the next tick.
         '{ACT_TICK, 8'hFF,      1'b1, '{7'd0, 7'd0, 7'd0, CAUSE_TICK}},
         '{ACT_BYTE, CHAR_S,     1'b0, '0},
         '{ACT_BYTE, CHAR_COLON, 1'b0, '0},
         '{ACT_BYTE, CHAR_MINUS, 1'b0, '0},
         '{ACT_BYTE, CHAR_ZERO + 8'd5, 1'b0, '0},
         '{ACT_BYTE, CHAR_LF,    1'b1, '{7'd0, 7'd0, 7'd0, CAUSE_SET}},
         '{ACT_BYTE, CHAR_LF,    1'b0, '0},
         '{ACT_BYTE, 8'hFF,      1'b0, '0},
         '{ACT_BYTE, CHAR_NUL,   1'b0, '0},
         '{ACT_BYTE, CHAR_LF,    1'b0, '0},
         '{ACT_TICK, CHAR_NUL,   1'b1, '{7'd0, 7'd0, 7'd1, CAUSE_TICK}}
      };
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.action  = ACT_BYTE;
      req_chan.rx_byte = CHAR_NUL;
      fail_count       = 0;
      items_done       = 0;
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      for (int i = 0; i < LINE_CAP; i++) begin
         shadow_line[i] = CHAR_NUL;
      end
      shadow_len     = 0;
      shadow_hours   = HOUR_RESET;
      shadow_minutes = '0;
      shadow_seconds = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].act, directed_rows[i].char_code, directed_rows[i].typed,
                   directed_rows[i].want);
      end
      drain_readings();

      // Phases: free running, sender idling, receiver stalling, then both.
      for (int ph = 0; ph < 4; ph++) begin
         req_idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 26 : 0;
         rsp_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 26 : 0;
         while (items_done < (ph + 1) * (ITEM_TARGET / 4)) begin
            send_random_line();
         end
         drain_readings();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS serial_set_time_of_day_clock");
      end else begin
         $display("FAIL serial_set_time_of_day_clock");
      end
      $finish;
   end

endmodule
